// ----- design/ptt_pkg.sv -----
// Package for the periodic timer table: codes, state encoding and the slot entry type.
// Used by periodic_timer_table_core. Depends on nothing else.
package ptt_pkg;

  localparam int DEF_TIMER_SLOTS = 32;
  localparam int RESULT_CAP      = 32;
  localparam int CAP_W           = $clog2(RESULT_CAP + 1);

  localparam int SVC_W  = 16;
  localparam int IVL_W  = 31;
  localparam int TIME_W = 48;

  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_POLL     = 2'd1,
    OP_DISPATCH = 2'd2,
    OP_RESERVED = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_TIMEOUT    = 3'd0,
    KIND_FIRED      = 3'd1,
    KIND_NONE       = 3'd2,
    KIND_REGISTERED = 3'd3,
    KIND_FULL       = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_POLL_END,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [SVC_W-1:0]  service;
    logic [IVL_W-1:0]  interval;
    logic [TIME_W-1:0] due;
  } slot_t;

  // Saturating add of a 31-bit interval onto a 48-bit time.
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [IVL_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {{(TIME_W + 1 - IVL_W){1'b0}}, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

// ----- design/periodic_timer_table_core.sv -----
// Periodic timer table: register, poll (earliest-due scan) and dispatch of timers.
// Holds the slot memory, the scan sequencer and the output register.
// Depends on ptt_pkg.
//
//  Channel | Direction | Beat contents
//  --------+-----------+-------------------------------------------------------------
//  in_     | slave     | tuser: opcode; tdata: service_id, interval_ms, now_ms
//  out_    | master    | tuser: kind; tdata: has_timeout, timeout_ms, fired_service;
//          |           | tlast: final result beat of the item
//
// Sequence: a register or table-full answer goes to S_FINISH; a poll scans the N
// registered timers, then S_POLL_END and S_FINISH; a dispatch scans, then S_FINISH.
// The scan reads one slot per cycle, bar dispatch stalls, from the 1R1W slot memory.
// Reset (rst_n, synchronous) empties the table and drops the trigger; slot
// memory contents are not cleared, as only written slots are ever read.
// Stalls: a held output beat pauses a dispatch scan only when a second fired
// timer must be reported; in_tready is high whenever the sequencer is idle.
module periodic_timer_table_core #(
  parameter int TIMER_SLOTS = ptt_pkg::DEF_TIMER_SLOTS
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // opcode
  input  logic [95:0] in_tdata,   // service_id[15:0], interval_ms[46:16], now_ms[94:47], pad
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [2:0]  out_tuser,  // kind
  output logic [47:0] out_tdata,  // has_timeout[0], timeout_ms[31:1], fired_service[47:32]
  output logic        out_tlast
);
  import ptt_pkg::*;

  localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
  localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  // Input field unpacking
  logic [SVC_W-1:0]  in_service;
  logic [IVL_W-1:0]  in_interval;
  logic [TIME_W-1:0] in_now;
  op_t               in_op;
  logic              in_beat;

  assign in_service  = in_tdata[15:0];
  assign in_interval = in_tdata[46:16];
  assign in_now      = in_tdata[94:47];
  assign in_op       = op_t'(in_tuser);
  assign in_beat     = in_tvalid && in_tready;

  // Registers
  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  proc_idx_r, proc_idx_nxt;
  logic [CAP_W-1:0]  nfired_r, nfired_nxt;
  logic [TIME_W-1:0] last_now_r, last_now_nxt;
  logic [TIME_W-1:0] trigger_due_r, trigger_due_nxt;
  logic              trigger_valid_r, trigger_valid_nxt;
  logic [TIME_W-1:0] min_r, min_nxt;

  assign in_tready   = (state_r == S_IDLE);

  // Pending result: held back until it is known whether it is the final beat.
  logic              pend_valid_r, pend_valid_nxt;
  kind_t             pend_kind_r, pend_kind_nxt;
  logic              pend_has_r, pend_has_nxt;
  logic [IVL_W-1:0]  pend_tmo_r, pend_tmo_nxt;
  logic [SVC_W-1:0]  pend_svc_r, pend_svc_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  kind_t             out_kind_r, out_kind_nxt;
  logic              out_has_r, out_has_nxt;
  logic [IVL_W-1:0]  out_tmo_r, out_tmo_nxt;
  logic [SVC_W-1:0]  out_svc_r, out_svc_nxt;
  logic              out_last_r, out_last_nxt;

  // Slot memory
  slot_t             mem [TIMER_SLOTS];
  slot_t             rd_q;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              mem_we;
  logic [IDX_W-1:0]  wr_addr;
  slot_t             wr_data;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Shared saturating adder: new due time on register, advanced due time on dispatch.
  logic [TIME_W-1:0] add_a;
  logic [IVL_W-1:0]  add_b;
  logic [TIME_W-1:0] add_sum;

  assign add_a   = (state_r == S_SCAN) ? rd_q.due : last_now_r;
  assign add_b   = (state_r == S_SCAN) ? rd_q.interval : in_interval;
  assign add_sum = sat_add(add_a, add_b);

  // Scan helpers
  logic              out_free;
  logic              scan_last;
  logic              match;
  logic              report;
  logic              stall;
  logic [CNT_W-1:0]  next_idx;
  logic              start_scan;
  logic              table_full;
  logic [TIME_W-1:0] wait_diff;
  logic [IVL_W-1:0]  wait_ms;

  assign out_free   = !out_valid_r || out_tready;
  assign next_idx   = proc_idx_r + CNT_W'(1);
  assign scan_last  = (next_idx == count_r);
  assign match      = (rd_q.due == trigger_due_r);
  assign report     = (nfired_r < CAP_W'(RESULT_CAP));
  assign stall      = (state_r == S_SCAN) && (op_r == OP_DISPATCH) && match && report
                      && pend_valid_r && !out_free;
  assign table_full = (count_r == CNT_W'(TIMER_SLOTS));
  assign start_scan = in_beat && (count_r != '0) &&
                      ((in_op == OP_POLL) || ((in_op == OP_DISPATCH) && trigger_valid_r));

  // Wait until the earliest due time, clamped at zero and saturated at 31 bits.
  assign wait_diff  = min_r - last_now_r;
  assign wait_ms    = (min_r <= last_now_r) ? '0 :
                      ((wait_diff[TIME_W-1:IVL_W] != '0) ? {IVL_W{1'b1}} :
                                                            wait_diff[IVL_W-1:0]);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          if (start_scan) begin
            state_nxt = S_SCAN;
          end else if (in_op != OP_RESERVED) begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_SCAN: begin
        if (!stall && scan_last) begin
          state_nxt = (op_r == OP_POLL) ? S_POLL_END : S_FINISH;
        end
      end
      S_POLL_END: state_nxt = S_FINISH;
      S_FINISH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    op_nxt            = op_r;
    count_nxt         = count_r;
    proc_idx_nxt      = proc_idx_r;
    nfired_nxt        = nfired_r;
    last_now_nxt      = last_now_r;
    trigger_due_nxt   = trigger_due_r;
    trigger_valid_nxt = trigger_valid_r;
    min_nxt           = min_r;
    pend_valid_nxt    = pend_valid_r;
    pend_kind_nxt     = pend_kind_r;
    pend_has_nxt      = pend_has_r;
    pend_tmo_nxt      = pend_tmo_r;
    pend_svc_nxt      = pend_svc_r;
    out_valid_nxt     = out_valid_r && !out_tready;
    out_kind_nxt      = out_kind_r;
    out_has_nxt       = out_has_r;
    out_tmo_nxt       = out_tmo_r;
    out_svc_nxt       = out_svc_r;
    out_last_nxt      = out_last_r;
    rd_en             = 1'b0;
    rd_addr           = '0;
    mem_we            = 1'b0;
    wr_addr           = count_r[IDX_W-1:0];
    wr_data           = rd_q;

    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          op_nxt       = in_op;
          proc_idx_nxt = '0;
          nfired_nxt   = '0;
          min_nxt      = {TIME_W{1'b1}};
          pend_has_nxt = 1'b0;
          pend_tmo_nxt = '0;
          pend_svc_nxt = '0;
          case (in_op)
            OP_REGISTER: begin
              pend_valid_nxt = 1'b1;
              if (table_full) begin
                pend_kind_nxt = KIND_FULL;
              end else begin
                pend_kind_nxt    = KIND_REGISTERED;
                mem_we           = 1'b1;
                wr_data.service  = in_service;
                wr_data.interval = in_interval;
                wr_data.due      = add_sum;
                count_nxt        = count_r + CNT_W'(1);
              end
            end
            OP_POLL: begin
              last_now_nxt = in_now;
              if (count_r == '0) begin
                trigger_due_nxt   = {TIME_W{1'b1}};
                trigger_valid_nxt = 1'b0;
                pend_valid_nxt    = 1'b1;
                pend_kind_nxt     = KIND_TIMEOUT;
              end
            end
            default: ;
          endcase
          if (start_scan) begin
            rd_en   = 1'b1;
            rd_addr = '0;
          end
        end
      end

      S_SCAN: begin
        if (!stall) begin
          if (op_r == OP_POLL) begin
            if (rd_q.due < min_r) begin
              min_nxt = rd_q.due;
            end
          end else if (match) begin
            mem_we      = 1'b1;
            wr_addr     = proc_idx_r[IDX_W-1:0];
            wr_data.due = add_sum;
            if (report) begin
              if (pend_valid_r) begin
                // An earlier fired timer goes out now; it is not the final beat.
                out_valid_nxt = 1'b1;
                out_kind_nxt  = pend_kind_r;
                out_has_nxt   = pend_has_r;
                out_tmo_nxt   = pend_tmo_r;
                out_svc_nxt   = pend_svc_r;
                out_last_nxt  = 1'b0;
              end
              pend_valid_nxt = 1'b1;
              pend_kind_nxt  = KIND_FIRED;
              pend_svc_nxt   = rd_q.service;
              nfired_nxt     = nfired_r + CAP_W'(1);
            end
          end
          proc_idx_nxt = next_idx;
          if (!scan_last) begin
            rd_en   = 1'b1;
            rd_addr = next_idx[IDX_W-1:0];
          end
        end
      end

      S_POLL_END: begin
        trigger_due_nxt   = min_r;
        trigger_valid_nxt = 1'b1;
        pend_valid_nxt    = 1'b1;
        pend_kind_nxt     = KIND_TIMEOUT;
        pend_has_nxt      = 1'b1;
        pend_tmo_nxt      = wait_ms;
      end

      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          if (pend_valid_r) begin
            out_kind_nxt = pend_kind_r;
            out_has_nxt  = pend_has_r;
            out_tmo_nxt  = pend_tmo_r;
            out_svc_nxt  = pend_svc_r;
          end else begin
            // Dispatch that fired nothing.
            out_kind_nxt = KIND_NONE;
            out_has_nxt  = 1'b0;
            out_tmo_nxt  = '0;
            out_svc_nxt  = '0;
          end
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      op_r            <= OP_REGISTER;
      count_r         <= '0;
      proc_idx_r      <= '0;
      nfired_r        <= '0;
      last_now_r      <= '0;
      trigger_due_r   <= {TIME_W{1'b1}};
      trigger_valid_r <= 1'b0;
      pend_valid_r    <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      op_r            <= op_nxt;
      count_r         <= count_nxt;
      proc_idx_r      <= proc_idx_nxt;
      nfired_r        <= nfired_nxt;
      last_now_r      <= last_now_nxt;
      trigger_due_r   <= trigger_due_nxt;
      trigger_valid_r <= trigger_valid_nxt;
      pend_valid_r    <= pend_valid_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    min_r        <= min_nxt;
    pend_kind_r  <= pend_kind_nxt;
    pend_has_r   <= pend_has_nxt;
    pend_tmo_r   <= pend_tmo_nxt;
    pend_svc_r   <= pend_svc_nxt;
    out_kind_r   <= out_kind_nxt;
    out_has_r    <= out_has_nxt;
    out_tmo_r    <= out_tmo_nxt;
    out_svc_r    <= out_svc_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {out_svc_r, out_tmo_r, out_has_r};
  assign out_tlast  = out_last_r;

  // Checks on the sequencer
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_valid_r)
    else $error("pending result left over while idle");

  a_fired_cap: assert property (@(posedge clk) disable iff (!rst_n)
    nfired_r <= CAP_W'(RESULT_CAP))
    else $error("fired count beyond result cap");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TIMER_SLOTS))
    else $error("slot count beyond table size");

  a_scan_write_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && (state_r == S_SCAN)) |-> (op_r == OP_DISPATCH))
    else $error("slot write during a poll scan");

  a_trigger_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    trigger_valid_r |-> (count_r != '0))
    else $error("trigger held with an empty table");

endmodule
